### rtl/core/triangle_point_classifier_core_defines.svh
// assertion macros for the triangle point classifier core
// used by triangle_point_classifier_core.sv, expects clk and rst_n in scope
`ifndef TRIANGLE_POINT_CLASSIFIER_CORE_DEFINES_SVH
`define TRIANGLE_POINT_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define TPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPC_ASSERT(lbl, prop, msg)
`define TPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/tpc_pkg.sv
// shared constants, codes and types of the triangle point classifier
// no dependencies
package tpc_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int TOL_FRAC_BITS_DEF = 20;
  localparam int TOL_BITS          = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd105;

  // register indexes of the config port
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_V0X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_V0Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_V1X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_V1Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_V2X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_V2Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOL = 3'd6;

  // position classes
  localparam int CLS_BITS = 3;
  localparam logic [CLS_BITS-1:0] CLS_INSIDE  = 3'd0;
  localparam logic [CLS_BITS-1:0] CLS_VERTEX  = 3'd1;
  localparam logic [CLS_BITS-1:0] CLS_EDGE    = 3'd2;
  localparam logic [CLS_BITS-1:0] CLS_OUTSIDE = 3'd3;
  localparam logic [CLS_BITS-1:0] CLS_DEGEN   = 3'd4;

  localparam int IDX_BITS = 2;
  localparam logic [IDX_BITS-1:0] IDX_NONE = 2'd3;

  // register stages from request to result
  localparam int PIPE_DEPTH = 8;

  typedef struct packed {
    logic [2:0] gt_lo;      // n_i*S > t
    logic [2:0] gt_hi;      // (D-n_i)*S > t
    logic [2:0] near_zero;  // |n_i*S| < t
    logic [2:0] near_full;  // |(D-n_i)*S| < t
    logic       degen;
    logic       d_neg;
    logic       det_pos;
    logic       det_neg;
  } tpc_flags_t;

endpackage

### rtl/core/triangle_point_classifier_core.sv
// A point taken with start runs through every register stage of the pipeline and then appears on out_valid.
// Throughput: one point per clock; busy is never raised and the results cannot be held off.
// The depth comes from the incircle determinant, whose wide products run through split multipliers.
// Reset (synchronous, rst_n low) clears the valid pipeline, zeroes the vertices, tolerance to 105.
// Depends on tpc_pkg, tpc_split_mul and triangle_point_classifier_core_defines.svh.
`include "triangle_point_classifier_core_defines.svh"

module triangle_point_classifier_core
  import tpc_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int TOL_FRAC_BITS = TOL_FRAC_BITS_DEF,
  localparam int CFG_W = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  output logic                         out_valid,
  output logic [CLS_BITS-1:0]          out_position_class,
  output logic [IDX_BITS-1:0]          out_vertex_index,
  output logic [IDX_BITS-1:0]          out_edge_index,
  output logic                         out_in_circumcircle
);

  localparam int DIW = COORD_BITS + 1;       // vertex minus point
  localparam int PW  = 2 * COORD_BITS + 2;   // one coordinate product
  localparam int SQW = 2 * COORD_BITS + 1;   // squared distance
  localparam int NDW = 2 * COORD_BITS + 3;   // sub-area numerator
  localparam int NW  = 2 * COORD_BITS + 5;   // numerators after sign fix
  localparam int TW  = NW + TOL_BITS;        // tolerance product
  localparam int CW  = NW + TOL_FRAC_BITS + TOL_BITS + 1;
  localparam int MPW = SQW + NDW + 1;        // one determinant term
  localparam int DW  = MPW + 2;              // determinant

  // configuration
  logic signed [COORD_BITS-1:0] vx_r [3];
  logic signed [COORD_BITS-1:0] vy_r [3];
  logic [TOL_BITS-1:0]          tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_V0X: vx_r[0] <= cfg_data[COORD_BITS-1:0];
        REG_V0Y: vy_r[0] <= cfg_data[COORD_BITS-1:0];
        REG_V1X: vx_r[1] <= cfg_data[COORD_BITS-1:0];
        REG_V1Y: vy_r[1] <= cfg_data[COORD_BITS-1:0];
        REG_V2X: vx_r[2] <= cfg_data[COORD_BITS-1:0];
        REG_V2Y: vy_r[2] <= cfg_data[COORD_BITS-1:0];
        REG_TOL: tol_r   <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the data stages
  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  // stage 1: vertices relative to the point
  logic signed [DIW-1:0] dx_r [3];
  logic signed [DIW-1:0] dy_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dx_r[i] <= DIW'(vx_r[i]) - DIW'(in_point_x);
      dy_r[i] <= DIW'(vy_r[i]) - DIW'(in_point_y);
    end
  end

  // stage 2: cross terms and squares
  logic signed [PW-1:0] cp_r [3];
  logic signed [PW-1:0] cq_r [3];
  logic signed [PW-1:0] sxx_r [3];
  logic signed [PW-1:0] syy_r [3];

  always_ff @(posedge clk) begin
    // n0 = b x c, n1 = c x a, n2 = a x b
    cp_r[0] <= PW'(dx_r[1]) * PW'(dy_r[2]);
    cq_r[0] <= PW'(dx_r[2]) * PW'(dy_r[1]);
    cp_r[1] <= PW'(dx_r[2]) * PW'(dy_r[0]);
    cq_r[1] <= PW'(dx_r[0]) * PW'(dy_r[2]);
    cp_r[2] <= PW'(dx_r[0]) * PW'(dy_r[1]);
    cq_r[2] <= PW'(dx_r[1]) * PW'(dy_r[0]);
    for (int i = 0; i < 3; i++) begin
      sxx_r[i] <= PW'(dx_r[i]) * PW'(dx_r[i]);
      syy_r[i] <= PW'(dy_r[i]) * PW'(dy_r[i]);
    end
  end

  // stage 3: barycentric numerators and lifted coordinates
  logic signed [NDW-1:0] n3_r [3];
  logic        [SQW-1:0] sq3_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n3_r[i]  <= NDW'(cp_r[i]) - NDW'(cq_r[i]);
      sq3_r[i] <= SQW'($unsigned(sxx_r[i])) + SQW'($unsigned(syy_r[i]));
    end
  end

  // stages 4 and 5 of the determinant terms live in the split multipliers
  logic signed [MPW-1:0] term5 [3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_term
    tpc_split_mul #(
      .A_BITS (SQW),
      .B_BITS (NDW)
    ) u_mul (
      .clk (clk),
      .a   (sq3_r[gi]),
      .b   (n3_r[gi]),
      .p   (term5[gi])
    );
  end

  // stage 4: doubled area as the sum of the numerators
  logic signed [NW-1:0]  d4_r;
  logic signed [NDW-1:0] n4_r [3];

  always_ff @(posedge clk) begin
    d4_r <= NW'(n3_r[0]) + NW'(n3_r[1]) + NW'(n3_r[2]);
    for (int i = 0; i < 3; i++) begin
      n4_r[i] <= n3_r[i];
    end
  end

  // stage 5: orientation made positive
  logic                 dz5_r, dneg5_r;
  logic signed [NW-1:0] dp5_r;
  logic signed [NW-1:0] np5_r [3];

  always_ff @(posedge clk) begin
    dz5_r   <= (d4_r == '0);
    dneg5_r <= d4_r[NW-1];
    dp5_r   <= d4_r[NW-1] ? -d4_r : d4_r;
    for (int i = 0; i < 3; i++) begin
      np5_r[i] <= d4_r[NW-1] ? -NW'(n4_r[i]) : NW'(n4_r[i]);
    end
  end

  // stage 6: tolerance, complements and determinant sum
  logic                 dz6_r, dneg6_r;
  logic [TW-1:0]        t6_r;
  logic signed [NW-1:0] n6_r [3];
  logic signed [NW-1:0] nn6_r [3];
  logic signed [NW-1:0] m6_r [3];
  logic signed [NW-1:0] mm6_r [3];
  logic signed [DW-1:0] det6_r;

  always_ff @(posedge clk) begin
    dz6_r   <= dz5_r;
    dneg6_r <= dneg5_r;
    t6_r    <= TW'(tol_r) * TW'($unsigned(dp5_r));
    for (int i = 0; i < 3; i++) begin
      n6_r[i]  <= np5_r[i];
      nn6_r[i] <= -np5_r[i];
      m6_r[i]  <= dp5_r - np5_r[i];
      mm6_r[i] <= np5_r[i] - dp5_r;
    end
    det6_r <= DW'(term5[0]) + DW'(term5[1]) + DW'(term5[2]);
  end

  // stage 7: tolerance compares on the scaled numerators
  logic signed [CW-1:0] tc;
  logic signed [CW-1:0] xn [3];
  logic signed [CW-1:0] xnn [3];
  logic signed [CW-1:0] xm [3];
  logic signed [CW-1:0] xmm [3];
  tpc_flags_t           flg_nxt, flg7_r;

  always_comb begin
    tc = $signed(CW'(t6_r));
    flg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      xn[i]  = CW'(n6_r[i]) <<< TOL_FRAC_BITS;
      xnn[i] = CW'(nn6_r[i]) <<< TOL_FRAC_BITS;
      xm[i]  = CW'(m6_r[i]) <<< TOL_FRAC_BITS;
      xmm[i] = CW'(mm6_r[i]) <<< TOL_FRAC_BITS;
      flg_nxt.gt_lo[i]     = xn[i] > tc;
      flg_nxt.gt_hi[i]     = xm[i] > tc;
      flg_nxt.near_zero[i] = (xn[i] < tc) && (xnn[i] < tc);
      flg_nxt.near_full[i] = (xm[i] < tc) && (xmm[i] < tc);
    end
    flg_nxt.degen   = dz6_r;
    flg_nxt.d_neg   = dneg6_r;
    flg_nxt.det_pos = !det6_r[DW-1] && (det6_r != '0);
    flg_nxt.det_neg = det6_r[DW-1];
  end

  always_ff @(posedge clk) begin
    flg7_r <= flg_nxt;
  end

  // stage 8: classification in test order
  logic [2:0]          vtx_hit;
  logic                all_in;
  logic [CLS_BITS-1:0] cls_nxt, cls_r;
  logic [IDX_BITS-1:0] vi_nxt, vi_r, ei_nxt, ei_r;
  logic                inc_nxt, inc_r;

  always_comb begin
    all_in     = &(flg7_r.gt_lo & flg7_r.gt_hi);
    vtx_hit[0] = flg7_r.near_full[0] && flg7_r.near_zero[1] && flg7_r.near_zero[2];
    vtx_hit[1] = flg7_r.near_full[1] && flg7_r.near_zero[2] && flg7_r.near_zero[0];
    vtx_hit[2] = flg7_r.near_full[2] && flg7_r.near_zero[0] && flg7_r.near_zero[1];
    cls_nxt = CLS_OUTSIDE;
    vi_nxt  = IDX_NONE;
    ei_nxt  = IDX_NONE;
    priority if (flg7_r.degen) begin
      cls_nxt = CLS_DEGEN;
    end else if (all_in) begin
      cls_nxt = CLS_INSIDE;
    end else if (vtx_hit[0]) begin
      cls_nxt = CLS_VERTEX;
      vi_nxt  = 2'd0;
    end else if (vtx_hit[1]) begin
      cls_nxt = CLS_VERTEX;
      vi_nxt  = 2'd1;
    end else if (vtx_hit[2]) begin
      cls_nxt = CLS_VERTEX;
      vi_nxt  = 2'd2;
    end else if (flg7_r.near_zero[0]) begin
      cls_nxt = CLS_EDGE;
      ei_nxt  = 2'd0;
    end else if (flg7_r.near_zero[1]) begin
      cls_nxt = CLS_EDGE;
      ei_nxt  = 2'd1;
    end else if (flg7_r.near_zero[2]) begin
      cls_nxt = CLS_EDGE;
      ei_nxt  = 2'd2;
    end else begin
      cls_nxt = CLS_OUTSIDE;
    end
    // clockwise and flat triangles flip the sign of the determinant
    inc_nxt = (!flg7_r.degen && !flg7_r.d_neg) ? flg7_r.det_pos : flg7_r.det_neg;
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
    vi_r  <= vi_nxt;
    ei_r  <= ei_nxt;
    inc_r <= inc_nxt;
  end

  assign out_valid           = vld_r[PIPE_DEPTH-1];
  assign out_position_class  = cls_r;
  assign out_vertex_index    = vi_r;
  assign out_edge_index      = ei_r;
  assign out_in_circumcircle = inc_r;

  `TPC_ASSERT(a_fixed_latency, (start && !busy) |-> ##(PIPE_DEPTH) out_valid, "request lost in pipeline")
  `TPC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result strobe after reset")
  `TPC_ASSERT(a_vertex_index, out_valid |-> ((out_position_class == CLS_VERTEX) == (out_vertex_index != IDX_NONE)), "vertex index mismatch")
  `TPC_ASSERT(a_edge_index, out_valid |-> ((out_position_class == CLS_EDGE) == (out_edge_index != IDX_NONE)), "edge index mismatch")

endmodule

### rtl/core/tpc_split_mul.sv
// two-stage unsigned by signed multiplier built from four half-width partial products
// no package dependencies
module tpc_split_mul #(
  parameter int A_BITS = 49,
  parameter int B_BITS = 51
) (
  input  logic                           clk,
  input  logic        [A_BITS-1:0]       a,
  input  logic signed [B_BITS-1:0]       b,
  output logic signed [A_BITS+B_BITS:0]  p
);

  localparam int H      = (B_BITS + 1) / 2;
  localparam int AH     = A_BITS - H;
  localparam int BH     = B_BITS - H;
  localparam int P_BITS = A_BITS + B_BITS + 1;
  localparam int LH_W   = H + BH + 1;
  localparam int HL_W   = AH + H;
  localparam int MW     = ((LH_W > HL_W + 1) ? LH_W : HL_W + 1) + 1;

  logic        [H-1:0]     a_lo, b_lo;
  logic        [AH-1:0]    a_hi;
  logic signed [BH-1:0]    b_hi;

  logic        [2*H-1:0]   ll_r;
  logic signed [LH_W-1:0]  lh_r;
  logic        [HL_W-1:0]  hl_r;
  logic signed [AH+BH:0]   hh_r;
  logic signed [MW-1:0]    mid;
  logic signed [P_BITS-1:0] p_nxt, p_r;

  assign a_lo = a[H-1:0];
  assign a_hi = a[A_BITS-1:H];
  assign b_lo = b[H-1:0];
  assign b_hi = b[B_BITS-1:H];

  always_ff @(posedge clk) begin
    ll_r <= a_lo * b_lo;
    lh_r <= $signed({1'b0, a_lo}) * b_hi;
    hl_r <= a_hi * b_lo;
    hh_r <= $signed({1'b0, a_hi}) * b_hi;
  end

  // high and low products do not overlap, the cross terms land in the middle
  always_comb begin
    mid   = MW'(lh_r) + MW'($signed({1'b0, hl_r}));
    p_nxt = $signed({hh_r, ll_r}) + (P_BITS'(mid) <<< H);
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule
